### hdl/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; expects clk and rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SKLM_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define SKLM_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hdl/sklm_pkg.sv
// Types and constants for the sorted key lookup block.
// No dependencies.
package sklm_pkg;

    localparam int KEY_W         = 24;
    localparam int HANDLE_W      = 16;
    localparam int ENTRY_INDEX_W = 10;
    localparam int ENTRY_COUNT_W = 11;
    localparam int VARIANT_W     = 2;
    localparam int HSTORE_W      = 4 * HANDLE_W;
    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    localparam logic REG_ENTRY_COUNT = 1'b0;

    localparam logic [KEY_W-1:0] MIRROR_BIT       = 24'h800000;
    localparam logic [7:0]       BANK_A_END       = 8'h40;
    localparam logic [7:0]       BANK_B_START     = 8'h80;
    localparam logic [7:0]       BANK_B_END       = 8'hC0;

    typedef struct packed {
        logic                     mode;
        logic [ENTRY_INDEX_W-1:0] entry_index;
        logic [KEY_W-1:0]         key_pc;
        logic [HANDLE_W-1:0]      handle_m0x0;
        logic [HANDLE_W-1:0]      handle_m0x1;
        logic [HANDLE_W-1:0]      handle_m1x0;
        logic [HANDLE_W-1:0]      handle_m1x1;
        logic                     flag_m;
        logic                     flag_x;
    } in_item_t;

    typedef struct packed {
        logic                found;
        logic                mirrored;
        logic [HANDLE_W-1:0] handle;
        logic [KEY_W-1:0]    matched_pc;
    } out_item_t;

endpackage

### hdl/sklm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sklm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/sorted_key_lookup_with_mirror_core.sv
// Sorted key lookup with bank mirror: top level, sequencer and table memories.
// Depends on sklm_pkg and sklm_ram.
//
//  channel  | signals                                   | carries
//  ---------+-------------------------------------------+--------------------------
//  in       | in_valid, in_ready, in_data               | load or lookup item
//  out      | out_valid, out_ready, out_data            | lookup result
//  cfg      | psel, penable, pwrite, paddr, pwdata,     | entry_count register
//           | prdata, pready                            |
//
//  Load: written to the key and handle memories on transfer.
//  Lookup: P = ceil(log2(count+1)) probes per pass, each a PROBE then a CMP state
//  (one key memory read port, registered read data); a pass ends in PROBE and CHECK,
//  one or two passes, then DONE hands over the result.
//  in_ready is low while a lookup runs; a waiting result holds only the final step.
//  rst_n clears control state and entry_count; table contents are not cleared.
module sorted_key_lookup_with_mirror_core
    import sklm_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int SW = (CW > ENTRY_COUNT_W) ? CW : ENTRY_COUNT_W;
    localparam int XW = (CW > ENTRY_INDEX_W) ? CW : ENTRY_INDEX_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PROBE = 3'd1;
    localparam logic [2:0] ST_CMP   = 3'd2;
    localparam logic [2:0] ST_CHECK = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]               state_reg, state_next;
    logic [ENTRY_COUNT_W-1:0] count_reg, count_next;
    logic [KEY_W-1:0]         key_reg, key_next;
    logic [KEY_W-1:0]         orig_key_reg, orig_key_next;
    logic [VARIANT_W-1:0]     variant_reg, variant_next;
    logic                     pass_reg, pass_next;
    logic [CW-1:0]            low_reg, low_next;
    logic [CW-1:0]            high_reg, high_next;
    logic [CW-1:0]            mid_reg, mid_next;
    out_item_t                res_reg, res_next;
    logic                     out_valid_reg, out_valid_next;
    out_item_t                out_data_reg, out_data_next;

    logic                     in_xfer;
    logic                     cfg_wr;
    logic [SW-1:0]            cnt_ext;
    logic [SW-1:0]            cnt_sat;
    logic [CW-1:0]            count_use;
    logic [XW-1:0]            idx_ext;
    logic                     slot_ok;
    logic [CW:0]              mid_sum;
    logic [CW-1:0]            mid_val;
    logic                     probe_go;
    logic                     ram_wr;
    logic [AW-1:0]            ram_wr_addr;
    logic                     ram_rd;
    logic [AW-1:0]            ram_rd_addr;
    logic [KEY_W-1:0]         key_rd;
    logic [HSTORE_W-1:0]      hnd_rd;
    logic [HSTORE_W-1:0]      hnd_wr;
    logic                     hit;
    logic [HANDLE_W-1:0]      hit_handle;
    logic [7:0]               bank;
    logic                     mirror_ok;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && (paddr[2] == REG_ENTRY_COUNT);
    assign prdata    = (paddr[2] == REG_ENTRY_COUNT) ? APB_DATA_W'(count_reg) : '0;

    assign cnt_ext   = SW'(count_reg);
    assign cnt_sat   = (cnt_ext > SW'(TABLE_DEPTH)) ? SW'(TABLE_DEPTH) : cnt_ext;
    assign count_use = cnt_sat[CW-1:0];

    assign idx_ext     = XW'(in_data.entry_index);
    assign slot_ok     = (idx_ext < XW'(TABLE_DEPTH));
    assign ram_wr      = in_xfer && (in_data.mode == MODE_LOAD) && slot_ok;
    assign ram_wr_addr = idx_ext[AW-1:0];
    assign hnd_wr      = {in_data.handle_m1x1, in_data.handle_m1x0,
                          in_data.handle_m0x1, in_data.handle_m0x0};

    assign mid_sum     = {1'b0, low_reg} + {1'b0, high_reg};
    assign mid_val     = mid_sum[CW:1];
    assign probe_go    = (low_reg < high_reg);
    assign ram_rd      = (state_reg == ST_PROBE);
    assign ram_rd_addr = probe_go ? mid_val[AW-1:0] : low_reg[AW-1:0];

    assign hit        = (low_reg < count_use) && (key_rd == key_reg);
    assign hit_handle = hit ? hnd_rd[variant_reg * HANDLE_W +: HANDLE_W] : '0;
    assign bank       = orig_key_reg[KEY_W-1:KEY_W-8];
    assign mirror_ok  = (bank < BANK_A_END) || ((bank >= BANK_B_START) && (bank < BANK_B_END));

    sklm_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (ram_wr),
        .wr_addr (ram_wr_addr),
        .wr_data (in_data.key_pc),
        .rd_en   (ram_rd),
        .rd_addr (ram_rd_addr),
        .rd_data (key_rd)
    );

    sklm_ram #(
        .WIDTH (HSTORE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_hnd_ram (
        .clk     (clk),
        .wr_en   (ram_wr),
        .wr_addr (ram_wr_addr),
        .wr_data (hnd_wr),
        .rd_en   (ram_rd),
        .rd_addr (ram_rd_addr),
        .rd_data (hnd_rd)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        key_next       = key_reg;
        orig_key_next  = orig_key_reg;
        variant_next   = variant_reg;
        pass_next      = pass_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        mid_next       = mid_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (cfg_wr)
        begin
            count_next = pwdata[ENTRY_COUNT_W-1:0];
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && (in_data.mode == MODE_LOOKUP))
                begin
                    key_next      = in_data.key_pc;
                    orig_key_next = in_data.key_pc;
                    variant_next  = {in_data.flag_m, in_data.flag_x};
                    pass_next     = 1'b0;
                    low_next      = '0;
                    high_next     = count_use;
                    state_next    = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                if (probe_go)
                begin
                    mid_next   = mid_val;
                    state_next = ST_CMP;
                end
                else
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CMP:
            begin
                if (key_rd < key_reg)
                begin
                    low_next = mid_reg + CW'(1);
                end
                else
                begin
                    high_next = mid_reg;
                end
                state_next = ST_PROBE;
            end
            ST_CHECK:
            begin
                if (hit_handle != '0)
                begin
                    res_next   = '{found: 1'b1, mirrored: pass_reg, handle: hit_handle,
                                   matched_pc: key_reg};
                    state_next = ST_DONE;
                end
                else if (!pass_reg && mirror_ok)
                begin
                    key_next   = key_reg ^ MIRROR_BIT;
                    pass_next  = 1'b1;
                    low_next   = '0;
                    high_next  = count_use;
                    state_next = ST_PROBE;
                end
                else
                begin
                    res_next   = '{found: 1'b0, mirrored: 1'b0, handle: '0,
                                   matched_pc: orig_key_reg};
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_data_next  = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            pass_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            pass_reg      <= pass_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        orig_key_reg <= orig_key_next;
        variant_reg  <= variant_next;
        low_reg      <= low_next;
        high_reg     <= high_next;
        mid_reg      <= mid_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

endmodule

### hdl/sklm_checker.sv
// Port-level checks for the sorted key lookup block, bound to its top level.
// Depends on sklm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sklm_checker
    import sklm_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  out_valid,
    input logic                  out_ready,
    input out_item_t             out_data,
    input logic                  pready
);

    `SKLM_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
    `SKLM_ASSERT_IMP(a_miss_clean, out_valid && !out_data.found,
        (out_data.handle == '0) && !out_data.mirrored)
    `SKLM_ASSERT_IMP(a_hit_nonzero, out_valid && out_data.found, out_data.handle != '0)
    `SKLM_ASSERT_IMP(a_mirror_bank, out_valid && out_data.mirrored,
        out_data.found && !out_data.matched_pc[KEY_W-2])
    `SKLM_ASSERT_IMP(a_pready, 1'b1, pready)

endmodule

bind sorted_key_lookup_with_mirror_core sklm_checker u_sklm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .pready    (pready)
);
